### hdl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// shared types and constants of the shelf rectangle packer
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int SHELF_LIMIT_DEF = 16;

	localparam int LEN_W   = 16;
	localparam int POS_W   = 17;
	localparam int SHELF_W = 4;
	localparam int CFG_IDX_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_HEIGHT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 8'd3;

	// one shelf record
	typedef struct packed {
		logic [LEN_W-1:0] base;
		logic [LEN_W-1:0] tall;
		logic [LEN_W-1:0] fill;
	} shelf_entry_t;

	// input item, first field in the low bits
	typedef struct packed {
		logic [LEN_W-1:0] item_h;
		logic [LEN_W-1:0] item_w;
	} in_item_t;

	// result item, first field in the low bits
	typedef struct packed {
		logic [6:0]         pad;
		logic               opened_shelf;
		logic [SHELF_W-1:0] shelf_number;
		logic               rotated;
		logic [LEN_W-1:0]   ext_h;
		logic [LEN_W-1:0]   ext_w;
		logic [POS_W-1:0]   pos_y;
		logic [POS_W-1:0]   pos_x;
		logic               placed;
	} out_item_t;

	localparam int IN_DATA_W  = $bits(in_item_t);
	localparam int OUT_DATA_W = $bits(out_item_t);

endpackage

### hdl/srp_shelf_store.sv
// ----------------------------------------------------------------------------
// srp_shelf_store
// shelf record memory with registered read and the fit test on the read entry
// ----------------------------------------------------------------------------
module srp_shelf_store #(
	parameter int DEPTH = srp_pkg::SHELF_LIMIT_DEF,
	parameter int IDX_W = 4
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           rd_addr,
	output srp_pkg::shelf_entry_t      rd_data,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_addr,
	input  srp_pkg::shelf_entry_t      wr_data,
	input  logic [srp_pkg::LEN_W-1:0]  cur_w,
	input  logic [srp_pkg::LEN_W-1:0]  cur_h,
	input  logic [srp_pkg::LEN_W-1:0]  bin_width,
	output logic                       hit
);

	srp_pkg::shelf_entry_t mem [DEPTH];
	srp_pkg::shelf_entry_t rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

	// shelf tall enough and free length left, sum at full width
	assign hit = (cur_h <= rd_data_s1.tall) &&
		(({1'b0, rd_data_s1.fill} + {1'b0, cur_w}) <= {1'b0, bin_width});

endmodule

### hdl/shelf_rectangle_packer.sv
// ----------------------------------------------------------------------------
// shelf_rectangle_packer
// shelf first-fit placement of rectangles into one bin
// ----------------------------------------------------------------------------
// search: the open shelves are read in order and the first hit is taken, else a new shelf
//   is opened on top of the used height; if neither fits, a non-square item gets a second
//   pass with width and height swapped
// throughput: one item at a time, s_tready rises together with m_tvalid of the previous
//   result; a result held by m_tready stalls only the next result
// reset: arst_n clears control state, registers and shelf count; the shelf memory needs no clearing
module shelf_rectangle_packer #(
	parameter int SHELF_LIMIT = srp_pkg::SHELF_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [srp_pkg::IN_DATA_W-1:0]     s_tdata,   // item_w, item_h
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [srp_pkg::OUT_DATA_W-1:0]    m_tdata,   // placed, pos_x, pos_y,
	                                                     // ext_w, ext_h,
	                                                     // rotated, shelf_number,
	                                                     // opened_shelf, zero pad
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srp_pkg::LEN_W-1:0]         cfg_data
);

	localparam int IDX_W = (SHELF_LIMIT > 1) ? $clog2(SHELF_LIMIT) : 1;
	localparam int CNT_W = $clog2(SHELF_LIMIT + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;

	// configuration registers
	logic [srp_pkg::LEN_W-1:0] bin_width_q, bin_height_q, origin_x_q, origin_y_q;

	// item under search
	logic [srp_pkg::LEN_W-1:0] item_w_q, item_h_q;
	logic [srp_pkg::LEN_W-1:0] cur_w_q, cur_h_q;   // current orientation
	logic                      rot_q;

	// packing state kept outside the memory
	logic [CNT_W-1:0]          open_q;
	logic [srp_pkg::LEN_W-1:0] used_q;

	// shelf scan
	logic [CNT_W-1:0]          next_q;      // next shelf to read
	logic                      rd_valid_s1; // read data in the store is live
	logic [IDX_W-1:0]          rd_idx_s1;   // shelf the read data belongs to

	// result register
	logic                      m_valid_q;
	srp_pkg::out_item_t        m_data_q;

	srp_pkg::in_item_t         in_item;
	srp_pkg::shelf_entry_t     rd_entry;
	srp_pkg::shelf_entry_t     wr_entry;
	srp_pkg::out_item_t        res;
	logic                      hit;
	logic                      hit_now, more, scan_done, new_ok, retry;
	logic                      finish, out_free, stall, rd_en, wr_en;
	logic [IDX_W-1:0]          slot;

	assign in_item   = srp_pkg::in_item_t'(s_tdata);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	// scan control: one read issued per cycle, test of the previous read
	assign hit_now   = rd_valid_s1 && hit;
	assign more      = (next_q < open_q);
	assign scan_done = !hit_now && !more && !rd_valid_s1 ||
		!hit_now && !more && rd_valid_s1;
	// new shelf on top of the used height
	assign new_ok    = (cur_w_q <= bin_width_q) &&
		(({1'b0, used_q} + {1'b0, cur_h_q}) <= {1'b0, bin_height_q}) &&
		(open_q < CNT_W'(SHELF_LIMIT));
	// swapped orientation only for a non-square item, once
	assign retry     = scan_done && !new_ok && !rot_q && (item_w_q != item_h_q);
	assign finish    = (state_q == ST_SCAN) && (hit_now || (scan_done && !retry));
	assign out_free  = !m_valid_q || m_tready;
	assign stall     = finish && !out_free;
	assign rd_en     = (state_q == ST_SCAN) && !hit_now && more;
	assign slot      = hit_now ? rd_idx_s1 : open_q[IDX_W-1:0];
	assign wr_en     = finish && !stall && (hit_now || new_ok);

	// record written back: a fresh shelf or the extended fill of a hit
	always_comb begin
		if (hit_now) begin
			wr_entry      = rd_entry;
			wr_entry.fill = rd_entry.fill + cur_w_q;
		end else begin
			wr_entry.base = used_q;
			wr_entry.tall = cur_h_q;
			wr_entry.fill = cur_w_q;
		end
	end

	// result fields, all zero when nothing fits
	always_comb begin
		res = '0;
		if (hit_now || new_ok) begin
			res.placed       = 1'b1;
			res.ext_w        = cur_w_q;
			res.ext_h        = cur_h_q;
			res.rotated      = rot_q;
			res.shelf_number = srp_pkg::SHELF_W'(slot);
			res.opened_shelf = !hit_now;
			if (hit_now) begin
				res.pos_x = {1'b0, origin_x_q} + {1'b0, rd_entry.fill};
				res.pos_y = {1'b0, origin_y_q} + {1'b0, rd_entry.base};
			end else begin
				res.pos_x = {1'b0, origin_x_q};
				res.pos_y = {1'b0, origin_y_q} + {1'b0, used_q};
			end
		end
	end

	srp_shelf_store #(
		.DEPTH (SHELF_LIMIT),
		.IDX_W (IDX_W)
	) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (next_q[IDX_W-1:0]),
		.rd_data   (rd_entry),
		.wr_en     (wr_en),
		.wr_addr   (slot),
		.wr_data   (wr_entry),
		.cur_w     (cur_w_q),
		.cur_h     (cur_h_q),
		.bin_width (bin_width_q),
		.hit       (hit)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q  <= '0;
			bin_height_q <= '0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				srp_pkg::REG_BIN_WIDTH:  bin_width_q  <= cfg_data;
				srp_pkg::REG_BIN_HEIGHT: bin_height_q <= cfg_data;
				srp_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_data;
				srp_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, scan pointer and packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rot_q       <= 1'b0;
			next_q      <= '0;
			rd_valid_s1 <= 1'b0;
			open_q      <= '0;
			used_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q     <= ST_SCAN;
						rot_q       <= 1'b0;
						next_q      <= '0;
						rd_valid_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						next_q      <= next_q + 1'b1;
						rd_valid_s1 <= 1'b1;
					end else if (retry) begin
						// second pass with width and height swapped
						rot_q       <= 1'b1;
						next_q      <= '0;
						rd_valid_s1 <= 1'b0;
					end else if (finish && !stall) begin
						state_q     <= ST_IDLE;
						rd_valid_s1 <= 1'b0;
						if (!hit_now && new_ok) begin
							open_q <= open_q + 1'b1;
							used_q <= used_q + cur_h_q;
						end
					end else if (!stall) begin
						rd_valid_s1 <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and orientation
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_w_q <= in_item.item_w;
			item_h_q <= in_item.item_h;
			cur_w_q  <= in_item.item_w;
			cur_h_q  <= in_item.item_h;
		end else if (state_q == ST_SCAN && !rd_en && retry) begin
			cur_w_q <= item_h_q;
			cur_h_q <= item_w_q;
		end
		if (rd_en) begin
			rd_idx_s1 <= next_q[IDX_W-1:0];
		end
	end

	// output register, a held result does not block the next acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish && !stall) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && !stall) begin
			m_data_q <= res;
		end
	end

endmodule

### hdl/srp_checker.sv
// ----------------------------------------------------------------------------
// srp_checker
// port-level checks of the shelf rectangle packer
// ----------------------------------------------------------------------------
module srp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [srp_pkg::OUT_DATA_W-1:0] m_tdata
);

	// one item in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// a result waiting for the sink holds its value
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an unplaced item reports all fields zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata == '0)
		else $error("unplaced result carries non-zero fields");

	// a new shelf is only reported with a placement
	a_open_placed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[72] |-> m_tdata[0])
		else $error("shelf opened without placement");

	// rotation only happens for a non-square item
	a_rot_nonsquare: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67] |-> m_tdata[50:35] != m_tdata[66:51])
		else $error("square item reported as rotated");

endmodule

bind shelf_rectangle_packer srp_checker u_srp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### bench/shelf_rectangle_packer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_rectangle_packer_test
// self-checking bench for the shelf first-fit rectangle packer: a directed
// run through zero-sized items, rotation, exact fits and shrinking registers,
// then randomised phases that open shelves up to the limit and fill them,
// every result checked against a cycle-free packing predictor
// ----------------------------------------------------------------------------
module shelf_rectangle_packer_test;

	localparam int SHELVES       = srp_pkg::SHELF_LIMIT_DEF;
	localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
	localparam int DRAIN_CYCLES  = 40;    // worst case is two walks over all open shelves

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [srp_pkg::IN_DATA_W-1:0]  s_tdata;   // item_w, item_h
	logic                           m_tvalid;
	logic                           m_tready;
	logic [srp_pkg::OUT_DATA_W-1:0] m_tdata;   // placed, pos_x, pos_y, ext_w, ext_h,
	                                           // rotated, shelf_number, opened_shelf, pad
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [srp_pkg::LEN_W-1:0]      cfg_data;

	shelf_rectangle_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// packing predictor: own copy of the registers and the shelf table
	// ------------------------------------------------------------------
	int bin_w_now, bin_h_now, org_x_now, org_y_now;
	int shelf_base [SHELVES];
	int shelf_tall [SHELVES];
	int shelf_fill [SHELVES];
	int shelves_now;
	int stack_height;

	srp_pkg::in_item_t  items_to_send [$];
	srp_pkg::out_item_t predicted_placements [$];

	// run statistics
	int items_sent, results_seen, placed_count, rotated_count, opened_count;
	int mismatch_count;

	// idling control, handshake bookkeeping between the clock edges
	bit in_idle_on, out_idle_on;
	bit in_taken, out_taken;
	int in_gap, out_stall;
	int quiet_cycles;

	// first fit over the open shelves, then a new shelf on top of the stack;
	// sums are done in int so nothing wraps at 16 bits
	function automatic bit find_spot(input int w, input int h, output int slot,
	                                 output bit fresh);
		slot  = 0;
		fresh = 1'b0;
		for (int k = 0; k < shelves_now; k++) begin
			if (h <= shelf_tall[k] && shelf_fill[k] + w <= bin_w_now) begin
				slot = k;
				return 1'b1;
			end
		end
		if (w <= bin_w_now && stack_height + h <= bin_h_now && shelves_now < SHELVES) begin
			slot  = shelves_now;
			fresh = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// works out the result of one item and commits the placement
	function automatic srp_pkg::out_item_t place_item(input srp_pkg::in_item_t it);
		srp_pkg::out_item_t r;
		int                 w, h, slot;
		bit                 fresh, rot, ok;
		r   = '0;
		w   = int'(it.item_w);
		h   = int'(it.item_h);
		rot = 1'b0;
		ok  = find_spot(w, h, slot, fresh);
		// a square item has only one orientation
		if (!ok && it.item_w != it.item_h) begin
			w   = int'(it.item_h);
			h   = int'(it.item_w);
			rot = 1'b1;
			ok  = find_spot(w, h, slot, fresh);
		end
		// a miss leaves every field at zero and the table untouched
		if (ok) begin
			r.placed = 1'b1;
			if (fresh) begin
				r.pos_x           = srp_pkg::POS_W'(org_x_now);
				r.pos_y           = srp_pkg::POS_W'(org_y_now + stack_height);
				shelf_base[slot]  = stack_height;
				shelf_tall[slot]  = h;
				shelf_fill[slot]  = w;
				shelves_now++;
				stack_height     += h;
				opened_count++;
			end else begin
				r.pos_x           = srp_pkg::POS_W'(org_x_now + shelf_fill[slot]);
				r.pos_y           = srp_pkg::POS_W'(org_y_now + shelf_base[slot]);
				shelf_fill[slot] += w;
			end
			r.ext_w        = w[srp_pkg::LEN_W-1:0];
			r.ext_h        = h[srp_pkg::LEN_W-1:0];
			r.rotated      = rot;
			r.shelf_number = slot[3:0];
			r.opened_shelf = fresh;
			placed_count++;
			if (rot)
				rotated_count++;
		end
		return r;
	endfunction

	// gap lengths: mostly none or short, now and then a long one
	function automatic int idle_len(input bit on);
		int pick;
		pick = $urandom_range(0, 99);
		if (!on || pick < 45)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// mostly items sized to the current bin, some shaped to need rotation,
	// squares, zero extents and full-range noise
	function automatic srp_pkg::in_item_t random_item(input int max_w, input int max_h);
		srp_pkg::in_item_t it;
		int                pick, w, h;
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			w = $urandom_range(1, max_w);
			h = $urandom_range(1, max_h);
		end else if (pick < 76) begin
			w = $urandom_range(0, max_h);
			h = w;
		end else if (pick < 86) begin
			// too tall as given, lies down on a shelf or a new one
			w = $urandom_range(0, max_h);
			h = $urandom_range(max_h, max_w);
		end else if (pick < 90) begin
			w = $urandom_range(0, 1) ? 0 : $urandom_range(0, max_w);
			h = (w != 0) ? 0 : $urandom_range(0, max_h);
		end else begin
			w = $urandom_range(0, 16'hFFFF);
			h = $urandom_range(0, 16'hFFFF);
		end
		it.item_w = w[srp_pkg::LEN_W-1:0];
		it.item_h = h[srp_pkg::LEN_W-1:0];
		return it;
	endfunction

	// ------------------------------------------------------------------
	// input side: acceptance and prediction at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predicted_placements.push_back(place_item(srp_pkg::in_item_t'(s_tdata)));
			items_sent++;
			in_taken = 1'b1;
		end
	end

	// input driver: holds an item until taken, then a random gap
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !in_taken)) begin
			if (in_taken) begin
				in_taken = 1'b0;
				in_gap   = idle_len(in_idle_on);
			end
			if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (items_to_send.size() > 0) begin
				s_tdata  <= items_to_send.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side: ready with random stalls after each taken result
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 1'b0;
				out_stall = idle_len(out_idle_on);
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void compare_field(input string fname, input logic [31:0] want,
	                                      input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: result %0d field %s expected %0h actual %0h",
			         $realtime, results_seen, fname, want, got);
			mismatch_count++;
		end
	endfunction

	// result monitor: each taken result against the oldest prediction
	always @(posedge clk) begin
		srp_pkg::out_item_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			out_taken = 1'b1;
			got       = srp_pkg::out_item_t'(m_tdata);
			if (predicted_placements.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0h",
				         $realtime, m_tdata);
				mismatch_count++;
			end else begin
				want = predicted_placements.pop_front();
				compare_field("placed",       32'(want.placed),       32'(got.placed));
				compare_field("pos_x",        32'(want.pos_x),        32'(got.pos_x));
				compare_field("pos_y",        32'(want.pos_y),        32'(got.pos_y));
				compare_field("ext_w",        32'(want.ext_w),        32'(got.ext_w));
				compare_field("ext_h",        32'(want.ext_h),        32'(got.ext_h));
				compare_field("rotated",      32'(want.rotated),      32'(got.rotated));
				compare_field("shelf_number", 32'(want.shelf_number), 32'(got.shelf_number));
				compare_field("opened_shelf", 32'(want.opened_shelf), 32'(got.opened_shelf));
				compare_field("pad",          32'(want.pad),          32'(got.pad));
			end
			results_seen++;
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
			         $realtime, STALL_LIMIT, predicted_placements.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequencing
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [srp_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val[srp_pkg::LEN_W-1:0];
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			srp_pkg::REG_BIN_WIDTH:  bin_w_now = val & 16'hFFFF;
			srp_pkg::REG_BIN_HEIGHT: bin_h_now = val & 16'hFFFF;
			srp_pkg::REG_ORIGIN_X:   org_x_now = val & 16'hFFFF;
			srp_pkg::REG_ORIGIN_Y:   org_y_now = val & 16'hFFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_bin(input int bw, input int bh, input int ox, input int oy);
		write_reg(srp_pkg::REG_BIN_WIDTH,  bw);
		write_reg(srp_pkg::REG_BIN_HEIGHT, bh);
		write_reg(srp_pkg::REG_ORIGIN_X,   ox);
		write_reg(srp_pkg::REG_ORIGIN_Y,   oy);
	endtask

	task automatic queue_item(input int w, input int h);
		srp_pkg::in_item_t it;
		it.item_w = w[srp_pkg::LEN_W-1:0];
		it.item_h = h[srp_pkg::LEN_W-1:0];
		items_to_send.push_back(it);
	endtask

	// every result in, nothing held on the input: safe to touch registers
	task automatic wait_idle;
		do
			@(posedge clk);
		while (items_to_send.size() != 0 || s_tvalid || predicted_placements.size() != 0);
	endtask

	task automatic run_phase(input int bw, input int bh, input int ox, input int oy,
	                         input int count, input int max_w, input int max_h,
	                         input bit in_idle, input bit out_idle);
		set_bin(bw, bh, ox, oy);
		in_idle_on  = in_idle;
		out_idle_on = out_idle;
		repeat (count)
			items_to_send.push_back(random_item(max_w, max_h));
		wait_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_idle_on  = 1'b1;
		out_idle_on = 1'b1;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers still at reset: zero-sized items open a zero-height shelf
		// and land on it, anything larger misses
		queue_item(0, 0);
		queue_item(0, 0);
		queue_item(1, 0);
		wait_idle();

		// narrow bin at the far corner, so positions need the 17th bit
		set_bin(100, 60, 16'hFFFF, 16'hFFFF);
		queue_item(30, 20);          // new shelf
		queue_item(15, 65);          // too tall as given, lies on the open shelf
		queue_item(10, 10);          // square, new shelf
		queue_item(5, 10);           // fills the first shelf to the exact width
		queue_item(16'hFFFF, 16'hFFFF);
		queue_item(16'hFFFF, 1);     // height sum would wrap at 16 bits
		queue_item(1, 16'hFFFF);
		queue_item(0, 16'hFFFF);
		queue_item(0, 5);            // zero width on a full shelf
		queue_item(25, 90);          // rotated onto a new shelf
		queue_item(100, 5);          // exact width and exact remaining height
		queue_item(3, 4);
		queue_item(4, 3);
		wait_idle();

		// registers shrunk under existing shelves: those over size take nothing
		set_bin(0, 0, 0, 0);
		queue_item(0, 0);
		queue_item(0, 7);
		queue_item(2, 2);
		wait_idle();

		// random phases: open shelves up to the limit, then widen the bin
		// stepwise, with one phase narrowing it again, so the open shelves keep filling
		run_phase(300,   400,   0,        0,        120, 120,   50,   1'b1, 1'b1);
		run_phase(1000,  900,   12345,    777,      120, 300,   80,   1'b0, 1'b0);
		run_phase(5000,  16'hFFFF, 16'hFFFF, 0,     120, 1500,  400,  1'b1, 1'b1);
		run_phase(16'hFFFF, 16'hFFFF, 0,  16'hFFFF, 150, 20000, 3000, 1'b1, 1'b0);
		run_phase(400,   100,   100,      100,      60,  200,   60,   1'b0, 1'b1);
		run_phase(16'hFFFF, 16'hFFFF, $urandom_range(0, 16'hFFFF),
		          $urandom_range(0, 16'hFFFF), 180, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (predicted_placements.size() != 0) begin
			$display("%0t: %0d results never arrived, expected %0h actual none",
			         $realtime, predicted_placements.size(), predicted_placements[0]);
			mismatch_count++;
		end

		$display("covered %0d items and %0d results: %0d placed, %0d rotated",
		         items_sent, results_seen, placed_count, rotated_count);
		$display("shelves opened %0d of %0d, stack height %0d, mismatches %0d",
		         opened_count, SHELVES, stack_height, mismatch_count);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
